/* design/assert_macros.svh */
// Assertion macros used by the line dilate/erode core design file.
// No dependencies; the including scope provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LGDE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lgde assertion failed");

// Next-cycle implication, disabled during reset
`define LGDE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lgde assertion failed");

`endif

/* design/lgde_pkg.sv */
// Shared constants, types and control struct for the line dilate/erode core.
// No dependencies.
package lgde_pkg;

  localparam int PIX_W      = 8;
  localparam int MAX_RADIUS = 15;
  localparam int RAD_W      = 4;
  localparam int CELL_N     = 2 * MAX_RADIUS + 1;
  localparam int IDX_W      = $clog2(CELL_N);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'd1;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } state_t;

  // Sequencer to datapath controls
  typedef struct packed {
    logic             shift;  // advance the cell chain with the new pixel
    logic             load;   // load the output register
    logic             last;   // loaded item closes the line
    logic [IDX_W-1:0] sel;    // cell whose accumulator gives the result
  } ctl_t;

endpackage

/* design/lgde_cell.sv */
// One window cell: running max and min of the newest pixels up to this cell.
// Depends on lgde_pkg.
module lgde_cell (
  input  logic                     clk,
  input  logic                     shift,
  input  logic [lgde_pkg::PIX_W-1:0] pix,
  input  logic [lgde_pkg::PIX_W-1:0] prev_max,
  input  logic [lgde_pkg::PIX_W-1:0] prev_min,
  output logic [lgde_pkg::PIX_W-1:0] max_q,
  output logic [lgde_pkg::PIX_W-1:0] min_q
);
  import lgde_pkg::*;

  logic [PIX_W-1:0] max_r, max_nxt;
  logic [PIX_W-1:0] min_r, min_nxt;

  always_comb begin
    max_nxt = (pix > prev_max) ? pix : prev_max;
    min_nxt = (pix < prev_min) ? pix : prev_min;
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      max_r <= max_nxt;
      min_r <= min_nxt;
    end
  end

  assign max_q = max_r;
  assign min_q = min_r;

endmodule

/* design/lgde_seq.sv */
// Line sequencer: pixel count, result timing and end-of-line flush.
// Depends on lgde_pkg.
module lgde_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_last,
  input  logic [lgde_pkg::RAD_W-1:0] radius,
  input  logic                       slot,
  output logic                       in_ready,
  output lgde_pkg::ctl_t             ctl,
  output logic                       flushing
);
  import lgde_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             pend_r, pend_nxt;
  logic             pend_last_r, pend_last_nxt;
  logic [RAD_W-1:0] k_r, k_nxt;

  logic [IDX_W-1:0] cnt_m1, rad_x, span_run, sel_run, span_fl, sel_fl;
  logic [RAD_W-1:0] k0;
  logic             need, acc;

  always_comb begin
    cnt_m1   = cnt_r - IDX_W'(1);
    rad_x    = IDX_W'(radius);
    need     = cnt_r > rad_x;
    span_run = {radius, 1'b0};
    sel_run  = (span_run < cnt_m1) ? span_run : cnt_m1;
    span_fl  = IDX_W'(k_r) + rad_x;
    sel_fl   = (span_fl < cnt_m1) ? span_fl : cnt_m1;
    k0       = (rad_x < cnt_m1) ? radius : cnt_m1[RAD_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    k_nxt         = k_r;
    in_ready      = 1'b0;
    acc           = 1'b0;
    ctl           = '0;
    case (state_r)
      ST_RUN: begin
        if (pend_r && pend_last_r) begin
          state_nxt = ST_FLUSH;
          k_nxt     = k0;
          pend_nxt  = 1'b0;
        end else begin
          in_ready = !(pend_r && need && !slot);
          if (pend_r && need && slot) begin
            ctl.load = 1'b1;
            ctl.sel  = sel_run;
          end
          acc       = in_valid && in_ready;
          ctl.shift = acc;
          // hold a result that could not load this cycle
          pend_nxt  = acc || (pend_r && need && !slot);
          if (acc) begin
            pend_last_nxt = in_last;
          end
          if (acc && cnt_r != IDX_W'(CELL_N)) begin
            cnt_nxt = cnt_r + IDX_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (slot) begin
          ctl.load = 1'b1;
          ctl.sel  = sel_fl;
          ctl.last = (k_r == '0);
          if (k_r == '0) begin
            state_nxt = ST_RUN;
            cnt_nxt   = '0;
          end else begin
            k_nxt = k_r - RAD_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      k_r         <= k_nxt;
    end
  end

  assign flushing = (state_r == ST_FLUSH);

endmodule

/* design/line_grey_dilate_erode_core.sv */
// Line grey dilation/erosion: windowed max or min over 2*radius+1 pixels.
// Results are read from the cell chain once their window is complete and
// held in the output register; throughput is one item per cycle within a
// line while the output is not stalled. Line end: input stalls while the
// flush sequencer drains remaining centres, one result per unstalled cycle.
// Reset (synchronous, rst_n low): mode max, radius 1, line empty, no output.
`include "assert_macros.svh"

module line_grey_dilate_erode_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lgde_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lgde_pkg::CFG_DATA_W-1:0] cfg_data,
  // Pixel input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] pixel_in
  input  logic                            in_tlast,   // line_end
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] pixel_out
  output logic                            out_tlast   // out_last
);
  import lgde_pkg::*;

  // Config regs: user must write only while the core is idle; not enforced.
  logic             mode_r;
  logic [RAD_W-1:0] radius_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      radius_r <= RAD_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_data[0];
        CFG_RADIUS: radius_r <= cfg_data[RAD_W-1:0];
        default:    ;
      endcase
    end
  end

  // Cell chain. Cell k holds the max and min of the newest k+1 pixels of the
  // line; each accepted pixel folds into the neighbor's values as they move
  // one cell down. Cells beyond the line's pixel count hold stale data and
  // are never selected.
  logic [PIX_W-1:0] pix;
  logic [PIX_W-1:0] max_a [CELL_N];
  logic [PIX_W-1:0] min_a [CELL_N];
  ctl_t             ctl;
  logic             slot;
  logic             flushing;

  assign pix = in_tdata[PIX_W-1:0];

  lgde_cell u_cell0 (
    .clk      (clk),
    .shift    (ctl.shift),
    .pix      (pix),
    .prev_max (pix),
    .prev_min (pix),
    .max_q    (max_a[0]),
    .min_q    (min_a[0])
  );

  for (genvar g = 1; g < CELL_N; g++) begin : g_cell
    lgde_cell u_cell (
      .clk      (clk),
      .shift    (ctl.shift),
      .pix      (pix),
      .prev_max (max_a[g-1]),
      .prev_min (min_a[g-1]),
      .max_q    (max_a[g]),
      .min_q    (min_a[g])
    );
  end

  // Sequencer: decides when a window is complete and drains the line end.
  lgde_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_last  (in_tlast),
    .radius   (radius_r),
    .slot     (slot),
    .in_ready (in_tready),
    .ctl      (ctl),
    .flushing (flushing)
  );

  // Output register: free when empty or being taken this cycle, so a new
  // result can load while the previous one leaves.
  logic             out_vld_r, out_vld_nxt;
  logic [PIX_W-1:0] out_pix_r, out_pix_nxt;
  logic             out_last_r, out_last_nxt;

  assign slot = !out_vld_r || out_tready;

  always_comb begin
    out_vld_nxt  = out_vld_r && !out_tready;
    out_pix_nxt  = out_pix_r;
    out_last_nxt = out_last_r;
    if (ctl.load) begin
      out_vld_nxt  = 1'b1;
      out_pix_nxt  = mode_r ? min_a[ctl.sel] : max_a[ctl.sel];
      out_last_nxt = ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pix_r  <= out_pix_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

  // Never overwrite a result that has not been taken.
  `LGDE_ASSERT_IMPL(a_no_overwrite, ctl.load, !out_vld_r || out_tready)
  // A line end item always blocks input in the following cycle.
  `LGDE_ASSERT_NEXT(a_end_blocks, in_tvalid && in_tready && in_tlast, !in_tready)
  // The chain stays frozen while the flush reads it.
  `LGDE_ASSERT_IMPL(a_flush_frozen, flushing, !ctl.shift && !in_tready)

endmodule
